@@ hdl/rrc_pkg.sv @@
`default_nettype none
package rrc_pkg;

    localparam int MAX_COLUMNS   = 512;
    localparam int MAX_ROWS      = 512;
    localparam int FRACTION_BITS = 8;
    localparam int ONE           = 1 << FRACTION_BITS;

    localparam int COORD_W = 24;
    localparam int T_W     = COORD_W + 2;
    localparam int BIG_W   = COORD_W - FRACTION_BITS;
    localparam int CFG_W   = 10;
    localparam int CHAR_W  = 8;
    localparam int COL_W   = $clog2(MAX_COLUMNS);
    localparam int ROW_W   = $clog2(MAX_ROWS);
    localparam int ADDR_W  = ROW_W + COL_W;
    localparam int DEPTH   = MAX_ROWS * MAX_COLUMNS;

    localparam logic [1:0] ACT_CLEAR = 2'd0;
    localparam logic [1:0] ACT_DRAW  = 2'd1;
    localparam logic [1:0] ACT_READ  = 2'd2;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_BAD     = 2'd1;
    localparam logic [1:0] ST_OUTSIDE = 2'd2;

    localparam logic [1:0] CFG_COLS = 2'd0;
    localparam logic [1:0] CFG_ROWS = 2'd1;
    localparam logic [1:0] CFG_BG   = 2'd2;

    typedef struct packed {
        logic [1:0]                action;
        logic                      outline_only;
        logic signed [COORD_W-1:0] left_edge;
        logic signed [COORD_W-1:0] top_edge;
        logic signed [COORD_W-1:0] rect_width;
        logic signed [COORD_W-1:0] rect_height;
        logic [CHAR_W-1:0]         paint_char;
        logic [8:0]                read_row;
        logic [8:0]                read_column;
    } t_in;

    typedef struct packed {
        logic [1:0]        status;
        logic [CHAR_W-1:0] pixel_char;
    } t_out;

    typedef struct packed {
        logic latch;
        logic prep1;
        logic prep2;
        logic step;
        logic rd;
        logic out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic skip;
        logic last;
    } t_dp_sts;

    function automatic logic [CFG_W-1:0] clamp_size(input logic [CFG_W-1:0] v,
                                                    input logic [CFG_W-1:0] maxv);
        logic [CFG_W-1:0] res;
        if (v == '0) begin
            res = CFG_W'(1);
        end else if (v > maxv) begin
            res = maxv;
        end else begin
            res = v;
        end
        return res;
    endfunction

endpackage
`default_nettype wire

@@ hdl/rectangle_raster_canvas.sv @@
// Character canvas of up to 512 x 512 eight-bit cells in one RAM.
// Input channel: i_in_valid / o_in_stall / i_in_data; a transfer takes one
// item (clear, draw rectangle, read pixel). Output channel: o_out_valid /
// i_out_stall / o_out_data; every item gives exactly one result transfer.
// Config: i_cfg_we / i_cfg_idx / i_cfg_data, written only while idle; this
// binds the user, the block itself does not enforce it. Items are handled
// one at a time; the RAM write port does one cell a cycle. A clear or draw
// passes the setup states PREP1 and PREP2, then scans its box: a clear
// writes every cell of the configured rows x cols, a draw the clipped box
// (outline only: its border), and an empty or bad box writes nothing. A
// read does one RAM read; an unused action goes straight to its result.
// The next item can be taken in the cycle in which its predecessor's result
// is first valid. The result sits in an output register and the next item
// is taken while it waits. If the receiver stalls, a finished item waits
// for the output register and no new item is taken until it is free.
// Reset clears control state and the config registers (columns 1, rows 1,
// background 32). The RAM is not cleared; cells read before any clear or
// draw has written them return undefined data.
`default_nettype none
module rectangle_raster_canvas (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_in_valid,
    output logic                           o_in_stall,
    input  wire rrc_pkg::t_in              i_in_data,
    output logic                           o_out_valid,
    input  wire logic                      i_out_stall,
    output rrc_pkg::t_out                  o_out_data,
    input  wire logic                      i_cfg_we,
    input  wire logic [1:0]                i_cfg_idx,
    input  wire logic [rrc_pkg::CFG_W-1:0] i_cfg_data
);

    rrc_pkg::t_dp_cmd cmd;
    rrc_pkg::t_dp_sts sts;

    logic                        ram_we;
    logic [rrc_pkg::ADDR_W-1:0]  ram_waddr;
    logic [rrc_pkg::CHAR_W-1:0]  ram_wdata;
    logic                        ram_re;
    logic [rrc_pkg::ADDR_W-1:0]  ram_raddr;
    logic [rrc_pkg::CHAR_W-1:0]  ram_rdata;

    rrc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_action    (i_in_data.action),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_cmd       (cmd),
        .i_sts       (sts)
    );

    rrc_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_data   (i_in_data),
        .o_out_data  (o_out_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .o_ram_we    (ram_we),
        .o_ram_waddr (ram_waddr),
        .o_ram_wdata (ram_wdata),
        .o_ram_re    (ram_re),
        .o_ram_raddr (ram_raddr),
        .i_ram_rdata (ram_rdata)
    );

    rrc_ram #(
        .WIDTH (rrc_pkg::CHAR_W),
        .DEPTH (rrc_pkg::DEPTH)
    ) u_canvas (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

endmodule
`default_nettype wire

@@ hdl/rrc_ram.sv @@
`default_nettype none
module rrc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

@@ hdl/rrc_ctrl.sv @@
`default_nettype none
module rrc_ctrl (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_in_valid,
    output logic                  o_in_stall,
    input  wire logic [1:0]       i_action,
    output logic                  o_out_valid,
    input  wire logic             i_out_stall,
    output rrc_pkg::t_dp_cmd      o_cmd,
    input  wire rrc_pkg::t_dp_sts i_sts
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_PREP1 = 3'd1;
    localparam logic [2:0] S_PREP2 = 3'd2;
    localparam logic [2:0] S_RUN   = 3'd3;
    localparam logic [2:0] S_READ  = 3'd4;
    localparam logic [2:0] S_DONE  = 3'd5;

    logic [2:0] r_state, n_state;
    logic       r_out_valid, n_out_valid;
    logic       accept;
    logic       slot_free;

    assign accept    = i_in_valid && (r_state == S_IDLE);
    assign slot_free = !r_out_valid || !i_out_stall;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    o_cmd.latch = 1'b1;
                    if (i_action == rrc_pkg::ACT_CLEAR || i_action == rrc_pkg::ACT_DRAW) begin
                        n_state = S_PREP1;
                    end else if (i_action == rrc_pkg::ACT_READ) begin
                        n_state = S_READ;
                    end else begin
                        n_state = S_DONE;
                    end
                end
            end
            S_PREP1: begin
                o_cmd.prep1 = 1'b1;
                n_state     = S_PREP2;
            end
            S_PREP2: begin
                o_cmd.prep2 = 1'b1;
                n_state     = S_RUN;
            end
            S_RUN: begin
                if (i_sts.skip) begin
                    n_state = S_DONE;
                end else begin
                    o_cmd.step = 1'b1;
                    if (i_sts.last) begin
                        n_state = S_DONE;
                    end
                end
            end
            S_READ: begin
                o_cmd.rd = 1'b1;
                n_state  = S_DONE;
            end
            S_DONE: begin
                if (slot_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.out_load) begin
            n_out_valid = 1'b1;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;

endmodule
`default_nettype wire

@@ hdl/rrc_dp.sv @@
`default_nettype none
module rrc_dp (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire rrc_pkg::t_in                       i_in_data,
    output rrc_pkg::t_out                           o_out_data,
    input  wire logic                               i_cfg_we,
    input  wire logic [1:0]                         i_cfg_idx,
    input  wire logic [rrc_pkg::CFG_W-1:0]          i_cfg_data,
    input  wire rrc_pkg::t_dp_cmd                   i_cmd,
    output rrc_pkg::t_dp_sts                        o_sts,
    output logic                                    o_ram_we,
    output logic [rrc_pkg::ADDR_W-1:0]              o_ram_waddr,
    output logic [rrc_pkg::CHAR_W-1:0]              o_ram_wdata,
    output logic                                    o_ram_re,
    output logic [rrc_pkg::ADDR_W-1:0]              o_ram_raddr,
    input  wire logic [rrc_pkg::CHAR_W-1:0]         i_ram_rdata
);

    localparam logic signed [rrc_pkg::T_W-1:0] ONE_T = rrc_pkg::T_W'(rrc_pkg::ONE);

    // configuration
    logic [rrc_pkg::CFG_W-1:0]  r_cols_cfg, r_rows_cfg;
    logic [rrc_pkg::CHAR_W-1:0] r_bg;

    // latched item
    logic [1:0]                         r_act;
    logic                               r_outl;
    logic signed [rrc_pkg::COORD_W-1:0] r_left, r_top, r_w, r_h;
    logic [rrc_pkg::CHAR_W-1:0]         r_chr;
    logic [rrc_pkg::ROW_W-1:0]          r_rrow;
    logic [rrc_pkg::COL_W-1:0]          r_rcol;

    // setup
    logic signed [rrc_pkg::T_W-1:0] r_right, r_bottom;
    logic signed [rrc_pkg::T_W-1:0] r_left_up, r_top_up;
    logic signed [rrc_pkg::T_W-1:0] r_lim_l, r_lim_t, r_lim_r, r_lim_b;
    logic                           r_bad;
    logic                           r_skip;

    // scan
    logic [rrc_pkg::COL_W-1:0]  r_c0, r_c1, r_col;
    logic [rrc_pkg::ROW_W-1:0]  r_r1, r_row;
    logic [rrc_pkg::CHAR_W-1:0] r_wchar;

    rrc_pkg::t_out r_out;

    logic [rrc_pkg::CFG_W-1:0]  cols_eff, rows_eff;
    logic [rrc_pkg::COL_W-1:0]  cols_m1;
    logic [rrc_pkg::ROW_W-1:0]  rows_m1;
    logic [rrc_pkg::BIG_W-1:0]  c0_full, r0_full, c1_full, r1_full;
    logic [rrc_pkg::COL_W-1:0]  c1_clip;
    logic [rrc_pkg::ROW_W-1:0]  r1_clip;
    logic                       draw_skip;
    logic signed [rrc_pkg::T_W-1:0] s_left, s_top, s_w, s_h, x_pos, y_pos;
    logic                       hit;
    logic                       outside;

    assign cols_eff = rrc_pkg::clamp_size(r_cols_cfg, rrc_pkg::CFG_W'(rrc_pkg::MAX_COLUMNS));
    assign rows_eff = rrc_pkg::clamp_size(r_rows_cfg, rrc_pkg::CFG_W'(rrc_pkg::MAX_ROWS));
    assign cols_m1  = rrc_pkg::COL_W'(cols_eff - rrc_pkg::CFG_W'(1));
    assign rows_m1  = rrc_pkg::ROW_W'(rows_eff - rrc_pkg::CFG_W'(1));

    assign s_left = rrc_pkg::T_W'(r_left);
    assign s_top  = rrc_pkg::T_W'(r_top);
    assign s_w    = rrc_pkg::T_W'(r_w);
    assign s_h    = rrc_pkg::T_W'(r_h);

    always_comb begin
        c0_full = (r_left <= 0) ? '0 : r_left_up[rrc_pkg::COORD_W-1:rrc_pkg::FRACTION_BITS];
        r0_full = (r_top <= 0) ? '0 : r_top_up[rrc_pkg::COORD_W-1:rrc_pkg::FRACTION_BITS];
        c1_full = r_right[rrc_pkg::COORD_W-1:rrc_pkg::FRACTION_BITS];
        r1_full = r_bottom[rrc_pkg::COORD_W-1:rrc_pkg::FRACTION_BITS];
        c1_clip = (c1_full > rrc_pkg::BIG_W'(cols_m1)) ? cols_m1
                                                       : c1_full[rrc_pkg::COL_W-1:0];
        r1_clip = (r1_full > rrc_pkg::BIG_W'(rows_m1)) ? rows_m1
                                                       : r1_full[rrc_pkg::ROW_W-1:0];
        draw_skip = r_bad || (r_right < 0) || (r_bottom < 0)
                    || (c0_full > rrc_pkg::BIG_W'(c1_clip))
                    || (r0_full > rrc_pkg::BIG_W'(r1_clip));
    end

    assign x_pos = $signed(rrc_pkg::T_W'(r_col) << rrc_pkg::FRACTION_BITS);
    assign y_pos = $signed(rrc_pkg::T_W'(r_row) << rrc_pkg::FRACTION_BITS);
    assign hit   = !r_outl || (x_pos < r_lim_l) || (y_pos < r_lim_t)
                   || (x_pos > r_lim_r) || (y_pos > r_lim_b);

    assign outside = ({1'b0, r_rrow} >= rows_eff) || ({1'b0, r_rcol} >= cols_eff);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cols_cfg <= rrc_pkg::CFG_W'(1);
            r_rows_cfg <= rrc_pkg::CFG_W'(1);
            r_bg       <= rrc_pkg::CHAR_W'(32);
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                rrc_pkg::CFG_COLS: r_cols_cfg <= i_cfg_data;
                rrc_pkg::CFG_ROWS: r_rows_cfg <= i_cfg_data;
                rrc_pkg::CFG_BG:   r_bg       <= i_cfg_data[rrc_pkg::CHAR_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_act  <= i_in_data.action;
            r_outl <= i_in_data.outline_only && (i_in_data.action == rrc_pkg::ACT_DRAW);
            r_left <= i_in_data.left_edge;
            r_top  <= i_in_data.top_edge;
            r_w    <= i_in_data.rect_width;
            r_h    <= i_in_data.rect_height;
            r_chr  <= i_in_data.paint_char;
            r_rrow <= i_in_data.read_row;
            r_rcol <= i_in_data.read_column;
        end
        if (i_cmd.prep1) begin
            r_right   <= s_left + s_w;
            r_bottom  <= s_top + s_h;
            r_left_up <= s_left + ONE_T - rrc_pkg::T_W'(1);
            r_top_up  <= s_top + ONE_T - rrc_pkg::T_W'(1);
            r_lim_l   <= s_left + ONE_T;
            r_lim_t   <= s_top + ONE_T;
            r_bad     <= (r_w <= 0) || (r_h <= 0);
        end
        if (i_cmd.prep2) begin
            r_lim_r <= r_right - ONE_T;
            r_lim_b <= r_bottom - ONE_T;
            if (r_act == rrc_pkg::ACT_CLEAR) begin
                r_c0    <= '0;
                r_col   <= '0;
                r_row   <= '0;
                r_c1    <= cols_m1;
                r_r1    <= rows_m1;
                r_wchar <= r_bg;
                r_skip  <= 1'b0;
            end else begin
                r_c0    <= c0_full[rrc_pkg::COL_W-1:0];
                r_col   <= c0_full[rrc_pkg::COL_W-1:0];
                r_row   <= r0_full[rrc_pkg::ROW_W-1:0];
                r_c1    <= c1_clip;
                r_r1    <= r1_clip;
                r_wchar <= r_chr;
                r_skip  <= draw_skip;
            end
        end
        if (i_cmd.step) begin
            if (r_col == r_c1) begin
                r_col <= r_c0;
                r_row <= r_row + rrc_pkg::ROW_W'(1);
            end else begin
                r_col <= r_col + rrc_pkg::COL_W'(1);
            end
        end
        if (i_cmd.out_load) begin
            if (r_act == rrc_pkg::ACT_DRAW && r_bad) begin
                r_out.status     <= rrc_pkg::ST_BAD;
                r_out.pixel_char <= '0;
            end else if (r_act == rrc_pkg::ACT_READ && outside) begin
                r_out.status     <= rrc_pkg::ST_OUTSIDE;
                r_out.pixel_char <= '0;
            end else if (r_act == rrc_pkg::ACT_READ) begin
                r_out.status     <= rrc_pkg::ST_OK;
                r_out.pixel_char <= i_ram_rdata;
            end else begin
                r_out.status     <= rrc_pkg::ST_OK;
                r_out.pixel_char <= '0;
            end
        end
    end

    assign o_sts.skip = r_skip;
    assign o_sts.last = (r_col == r_c1) && (r_row == r_r1);

    assign o_ram_we    = i_cmd.step && hit;
    assign o_ram_waddr = {r_row, r_col};
    assign o_ram_wdata = r_wchar;
    assign o_ram_re    = i_cmd.rd;
    assign o_ram_raddr = {r_rrow, r_rcol};

    assign o_out_data = r_out;

endmodule
`default_nettype wire
